// ===== rtl/glj_pkg.sv =====
package glj_pkg;

    // Widest line the block supports, and the longest line in words that it implies.
    localparam int MAX_WIDTH  = 32;
    localparam int PEND_DEPTH = (MAX_WIDTH + 1) / 2;

    // Field widths of the stream words.
    localparam int LEN_W       = 6;
    localparam int SPC_W       = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Line width after reset.
    localparam int WIDTH_RESET = 32;

    // Pending line bookkeeping.
    localparam int CNT_W = $clog2(PEND_DEPTH + 1);
    localparam int IDX_W = $clog2(PEND_DEPTH);
    localparam int FIT_W = LEN_W + 1;

    // Gap divider: leftover columns divided by the number of gaps.
    localparam int DIVD_W = LEN_W;
    localparam int DIVS_W = IDX_W;
    localparam int STEP_W = $clog2(DIVD_W);

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [DIVS_W-1:0] rem;
    } div_res_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    typedef enum logic {
        MODE_FULL = 1'b0,
        MODE_LAST = 1'b1
    } emit_mode_t;

    // Line width clamped to the supported range.
    function automatic logic [LEN_W-1:0] eff_width(input logic [LEN_W-1:0] w);
        logic [LEN_W-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = LEN_W'(1);
        end
        else if (int'(w) > MAX_WIDTH)
        begin
            r = LEN_W'(MAX_WIDTH);
        end
        return r;
    endfunction

    // Word length clamped to one through the effective width.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] w);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
        begin
            r = LEN_W'(1);
        end
        if (r > w)
        begin
            r = w;
        end
        return r;
    endfunction

endpackage

// ===== rtl/glj_div.sv =====
module glj_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [glj_pkg::DIVD_W-1:0]   dividend,
    input  logic [glj_pkg::DIVS_W-1:0]   divisor,
    output glj_pkg::div_res_t            res
);

    localparam int DIVD_W = glj_pkg::DIVD_W;
    localparam int DIVS_W = glj_pkg::DIVS_W;
    localparam int STEP_W = glj_pkg::STEP_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic [DIVD_W-1:0] quo_reg,  quo_next;
    logic [DIVS_W-1:0] rem_reg,  rem_next;
    logic [DIVS_W-1:0] dvs_reg,  dvs_next;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    // One quotient bit per cycle, most significant first (restoring division).
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = STEP_W'(DIVD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], ge};
            rem_next = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== rtl/greedy_line_justifier.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: word_length; tlast: final_word
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: placed_length, lead_spaces,
//                                              trail_spaces; tuser: line_end;
//                                              tlast: run_last
// cfg       in   cfg_valid/cfg_ready           cfg_data: line_width
//
// A word that only joins the pending line is written to the memory while the
// sequencer stays idle. A word that closes a line runs the gap divider when the
// line has two or more words, then a memory read step and an output load step
// per emitted word, since the memory has a single read port; a final word also
// sends out the last line. Reset leaves an empty line 32 columns wide and the
// memory uncleared. A stalled output holds the sequencer in its load step.

module greedy_line_justifier (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] word_length, [7:6] zero
    input  logic        s_axis_tlast,   // final_word

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] placed_length, [10:6] lead_spaces,
                                        // [15:11] trail_spaces
    output logic        m_axis_tuser,   // line_end
    output logic        m_axis_tlast,   // run_last

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // line_width
);

    localparam int LEN_W      = glj_pkg::LEN_W;
    localparam int SPC_W      = glj_pkg::SPC_W;
    localparam int CNT_W      = glj_pkg::CNT_W;
    localparam int IDX_W      = glj_pkg::IDX_W;
    localparam int FIT_W      = glj_pkg::FIT_W;
    localparam int PEND_DEPTH = glj_pkg::PEND_DEPTH;

    // Configured width and the pending line's state.
    logic [LEN_W-1:0]        width_reg, width_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LEN_W-1:0]        space_reg, space_next;
    logic signed [FIT_W-1:0] fit_reg,   fit_next;

    // Emission sequencer.
    glj_pkg::state_t         state_reg, state_next;
    glj_pkg::emit_mode_t     mode_reg,  mode_next;
    logic [CNT_W-1:0]        n_reg,     n_next;
    logic [IDX_W-1:0]        idx_reg,   idx_next;
    logic [SPC_W-1:0]        pad_reg,   pad_next;
    logic                    pend_last_reg, pend_last_next;
    logic [LEN_W-1:0]        new_len_reg,   new_len_next;
    logic [SPC_W-1:0]        last_pad_reg,  last_pad_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]        m_len_reg,   m_len_next;
    logic [SPC_W-1:0]        m_lead_reg,  m_lead_next;
    logic [SPC_W-1:0]        m_trail_reg, m_trail_next;
    logic                    m_end_reg,   m_end_next;
    logic                    m_last_reg,  m_last_next;

    // Pending-length memory, one write and one registered read per cycle.
    logic [LEN_W-1:0]        mem [PEND_DEPTH];
    logic [LEN_W-1:0]        rdata_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [LEN_W-1:0]        wr_data;

    logic                    accept;
    logic                    out_free;
    logic [LEN_W-1:0]        weff;
    logic [LEN_W-1:0]        len_c;
    logic                    fits;
    logic [LEN_W-1:0]        space_fit;
    logic [CNT_W-1:0]        count_inc;
    logic [LEN_W-1:0]        space_new_line;
    logic                    word_last;
    logic                    div_start;
    glj_pkg::div_res_t       div_res;

    assign s_axis_tready = (state_reg == glj_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign weff           = glj_pkg::eff_width(width_reg);
    assign len_c          = glj_pkg::clamp_len(s_axis_tdata[LEN_W-1:0], weff);
    assign fits           = (count_reg < CNT_W'(PEND_DEPTH)) &&
                            ($signed({1'b0, len_c}) <= fit_reg);
    assign space_fit      = space_reg - len_c;
    assign count_inc      = count_reg + CNT_W'(1);
    assign space_new_line = weff - len_c;
    assign word_last      = (CNT_W'(idx_reg) == (n_reg - CNT_W'(1)));

    // The gaps of a full line are its leftover columns split over n-1 places.
    assign div_start = accept && !fits && (count_reg > CNT_W'(1));

    glj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (space_reg),
        .divisor  (IDX_W'(count_reg - CNT_W'(1))),
        .res      (div_res)
    );

    always_comb
    begin
        width_next     = width_reg;
        count_next     = count_reg;
        space_next     = space_reg;
        fit_next       = fit_reg;
        state_next     = state_reg;
        mode_next      = mode_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pad_next       = pad_reg;
        pend_last_next = pend_last_reg;
        new_len_next   = new_len_reg;
        last_pad_next  = last_pad_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_len_next     = m_len_reg;
        m_lead_next    = m_lead_reg;
        m_trail_next   = m_trail_reg;
        m_end_next     = m_end_reg;
        m_last_next    = m_last_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = len_c;

        // A new width takes effect at once only while no line is pending.
        if (cfg_valid)
        begin
            width_next = cfg_data;
            if (count_reg == '0)
            begin
                space_next = glj_pkg::eff_width(cfg_data);
                fit_next   = $signed({1'b0, glj_pkg::eff_width(cfg_data)});
            end
        end

        unique case (state_reg)
            glj_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if (fits)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = count_reg[IDX_W-1:0];
                        if (s_axis_tlast)
                        begin
                            // Word joins the line, and the whole line goes out
                            // as the last line with single spaces.
                            mode_next  = glj_pkg::MODE_LAST;
                            n_next     = count_inc;
                            pad_next   = SPC_W'(space_fit - LEN_W'(count_reg));
                            state_next = glj_pkg::S_READ;
                            count_next = '0;
                            space_next = weff;
                            fit_next   = $signed({1'b0, weff});
                        end
                        else
                        begin
                            count_next = count_inc;
                            space_next = space_fit;
                            fit_next   = $signed({1'b0, space_fit}) -
                                         $signed(FIT_W'(count_inc));
                        end
                    end
                    else
                    begin
                        // Word does not fit: justify the pending line first,
                        // then the word opens the next line.
                        mode_next      = glj_pkg::MODE_FULL;
                        n_next         = count_reg;
                        pad_next       = (count_reg == CNT_W'(1)) ? SPC_W'(space_reg) : '0;
                        new_len_next   = len_c;
                        pend_last_next = s_axis_tlast;
                        last_pad_next  = SPC_W'(space_new_line);
                        state_next     = div_start ? glj_pkg::S_DIV : glj_pkg::S_READ;
                        if (s_axis_tlast)
                        begin
                            count_next = '0;
                            space_next = weff;
                            fit_next   = $signed({1'b0, weff});
                        end
                        else
                        begin
                            count_next = CNT_W'(1);
                            space_next = space_new_line;
                            fit_next   = $signed({1'b0, space_new_line}) -
                                         $signed(FIT_W'(1));
                        end
                    end
                end
            end
            glj_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = glj_pkg::S_READ;
                end
            end
            glj_pkg::S_READ:
            begin
                state_next = glj_pkg::S_LOAD;
            end
            glj_pkg::S_LOAD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_len_next   = rdata_reg;
                    m_end_next   = word_last;
                    m_trail_next = word_last ? pad_reg : '0;
                    m_last_next  = word_last &&
                                   !(mode_reg == glj_pkg::MODE_FULL && pend_last_reg);
                    if (idx_reg == '0)
                    begin
                        m_lead_next = '0;
                    end
                    else if (mode_reg == glj_pkg::MODE_LAST)
                    begin
                        m_lead_next = SPC_W'(1);
                    end
                    else
                    begin
                        // Leftmost gaps take one extra space each for the remainder.
                        m_lead_next = SPC_W'(div_res.quot) +
                                      SPC_W'(idx_reg <= div_res.rem);
                    end

                    if (word_last)
                    begin
                        if (mode_reg == glj_pkg::MODE_FULL)
                        begin
                            // The word that did not fit becomes entry zero.
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = new_len_reg;
                        end
                        if (mode_reg == glj_pkg::MODE_FULL && pend_last_reg)
                        begin
                            mode_next      = glj_pkg::MODE_LAST;
                            n_next         = CNT_W'(1);
                            pad_next       = last_pad_reg;
                            idx_next       = '0;
                            pend_last_next = 1'b0;
                            state_next     = glj_pkg::S_READ;
                        end
                        else
                        begin
                            state_next = glj_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = glj_pkg::S_READ;
                    end
                end
            end
            default:
            begin
                state_next = glj_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= LEN_W'(glj_pkg::WIDTH_RESET);
            count_reg     <= '0;
            space_reg     <= LEN_W'(glj_pkg::WIDTH_RESET);
            fit_reg       <= FIT_W'(glj_pkg::WIDTH_RESET);
            state_reg     <= glj_pkg::S_IDLE;
            mode_reg      <= glj_pkg::MODE_FULL;
            n_reg         <= '0;
            idx_reg       <= '0;
            pend_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            count_reg     <= count_next;
            space_reg     <= space_next;
            fit_reg       <= fit_next;
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pend_last_reg <= pend_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg      <= pad_next;
        new_len_reg  <= new_len_next;
        last_pad_reg <= last_pad_next;
        m_len_reg    <= m_len_next;
        m_lead_reg   <= m_lead_next;
        m_trail_reg  <= m_trail_next;
        m_end_reg    <= m_end_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == glj_pkg::S_READ)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_trail_reg, m_lead_reg, m_len_reg};
    assign m_axis_tuser  = m_end_reg;
    assign m_axis_tlast  = m_last_reg;

    // The pending line never holds more words than the memory has entries.
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PEND_DEPTH))
        else $error("pending word count exceeds memory depth");

    // On a nonempty line the fit limit tracks free columns minus needed gaps.
    ap_fit_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |->
            (fit_reg == ($signed({1'b0, space_reg}) - $signed(FIT_W'(count_reg)))))
        else $error("fit limit out of step with pending line");

    // A new output word appears only from the load step of the sequencer.
    ap_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == glj_pkg::S_LOAD))
        else $error("output word loaded outside the load step");

endmodule
